[rtl/fifo_queue_search_remove_assert.svh]
// Assertion macros shared by the queue RTL.
`ifndef FIFO_QUEUE_SEARCH_REMOVE_ASSERT_SVH
`define FIFO_QUEUE_SEARCH_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FQSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// Next-cycle implication, disabled during reset.
`define FQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

[rtl/fqsr_pkg.sv]
// Package with sizes, codes and helpers for the search-and-remove queue.
`timescale 1ns / 1ps
`default_nettype none
package fqsr_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_ENQ    = 3'd0,
        CMD_DEQ    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_EXISTS = 3'd3,
        CMD_REMOVE = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ENQ,
        CELL_DEQ,
        CELL_MATCH,
        CELL_REMOVE,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [DATA_WIDTH-1:0] word;
        logic [DATA_WIDTH-1:0] sel;
    } cell_ctrl_t;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [31:0] v);
        logic [63:0] t;
        t = {32'd0, v};
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_word(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[31:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] match_sel(input logic [31:0] km);
        logic [63:0] t;
        t = {32'hFFFF_FFFF, km};
        return t[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/fqsr_cell.sv]
// One queue slot: holds a word, its occupancy and its match flag.
`timescale 1ns / 1ps
`default_nettype none
module fqsr_cell (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  fqsr_pkg::cell_ctrl_t       ctrl,
    input  wire                              occ_prev,
    input  wire  [fqsr_pkg::DATA_WIDTH-1:0]  data_next,
    input  wire                              occ_next,
    input  wire                              hit_in,
    output logic [fqsr_pkg::DATA_WIDTH-1:0]  data,
    output logic                             occ,
    output logic                             hit_out
);
    import fqsr_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next_val;
    logic                  occ_reg, occ_next_val;
    logic                  match_reg, match_next;

    assign data    = data_reg;
    assign occ     = occ_reg;
    assign hit_out = hit_in | match_reg;

    always_comb begin
        data_next_val = data_reg;
        occ_next_val  = occ_reg;
        match_next    = match_reg;
        case (ctrl.op)
            CELL_ENQ: begin
                if (!occ_reg && occ_prev) begin
                    data_next_val = ctrl.word;
                    occ_next_val  = 1'b1;
                end
            end
            CELL_DEQ: begin
                data_next_val = data_next;
                occ_next_val  = occ_next;
            end
            CELL_MATCH: begin
                match_next = occ_reg && (((data_reg ^ ctrl.word) & ctrl.sel) == '0);
            end
            CELL_REMOVE: begin
                if (hit_in | match_reg) begin
                    data_next_val = data_next;
                    occ_next_val  = occ_next;
                end
            end
            CELL_CLEAR: begin
                occ_next_val = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            occ_reg   <= occ_next_val;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next_val;
    end

endmodule
`default_nettype wire

[rtl/fifo_queue_search_remove.sv]
// Top level: bounded queue with masked search and ordered remove.
//
// Usage:
//   Command channel s_*: s_cmd with s_value (word to enqueue, or search key).
//   Result channel m_*: one beat per command with m_status, m_data, m_found
//   and m_count (entries held after the command).
//   Config channel cfg_*: cfg_data writes key_mask; cfg_ready is always high.
//   Write it only while no command is in flight.
// Timing:
//   Enqueue, dequeue, peek and clear go from accept to S_EXEC, which registers
//   the result; exists and remove pass through S_SEARCH first, for every cell to
//   register its compare before the remove ripple closes the gap. A new command is
//   accepted the cycle after the previous one issues its result, so this command
//   sequencer takes no new command while one is still in progress.
// Reset:
//   aresetn low empties the queue and sets key_mask to all ones.
// Stall:
//   A pending result is held in the output register while the next command
//   is accepted; that command waits in its final step until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_search_remove_assert.svh"
module fifo_queue_search_remove (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [31:0] s_value,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_data,
    output logic        m_found,
    output logic [4:0]  m_count,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);
    import fqsr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EXEC} state_t;

    state_t                state_reg;
    logic [2:0]            cmd_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [31:0]           key_mask_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg, status_next;
    logic [31:0]           m_data_reg, data_out_next;
    logic                  m_found_reg, found_next;
    logic [4:0]            m_count_reg;

    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] data_vec [DEPTH];
    logic [DEPTH-1:0]      occ_vec;
    logic [DEPTH-1:0]      hit_vec;

    logic exec_go, full, empty, hit_any;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_data    = m_data_reg;
    assign m_found   = m_found_reg;
    assign m_count   = m_count_reg;

    assign exec_go = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign hit_any = hit_vec[DEPTH-1];

    always_comb begin
        ctrl.word = key_reg;
        ctrl.sel  = match_sel(key_mask_reg);
        ctrl.op   = CELL_HOLD;
        if (state_reg == S_SEARCH) begin
            ctrl.op = CELL_MATCH;
        end else if (exec_go) begin
            case (cmd_reg)
                CMD_ENQ:    ctrl.op = full  ? CELL_HOLD : CELL_ENQ;
                CMD_DEQ:    ctrl.op = empty ? CELL_HOLD : CELL_DEQ;
                CMD_REMOVE: ctrl.op = CELL_REMOVE;
                CMD_CLEAR:  ctrl.op = CELL_CLEAR;
                default:    ctrl.op = CELL_HOLD;
            endcase
        end
    end

    always_comb begin
        status_next   = ST_OK;
        data_out_next = '0;
        found_next    = 1'b0;
        count_next    = count_reg;
        case (cmd_reg)
            CMD_ENQ: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    data_out_next = from_word(data_vec[0]);
                    count_next    = count_reg - 1'b1;
                end
            end
            CMD_PEEK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    data_out_next = from_word(data_vec[0]);
                end
            end
            CMD_EXISTS: begin
                if (hit_any) begin
                    found_next = 1'b1;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_REMOVE: begin
                if (hit_any) begin
                    found_next = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                  occ_prev_w, occ_next_w, hit_in_w;
            logic [DATA_WIDTH-1:0] data_next_w;
            if (gi == 0) begin : g_head
                assign occ_prev_w = 1'b1;
                assign hit_in_w   = 1'b0;
            end else begin : g_body
                assign occ_prev_w = occ_vec[gi-1];
                assign hit_in_w   = hit_vec[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign occ_next_w  = 1'b0;
                assign data_next_w = '0;
            end else begin : g_link
                assign occ_next_w  = occ_vec[gi+1];
                assign data_next_w = data_vec[gi+1];
            end
            fqsr_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .occ_prev  (occ_prev_w),
                .data_next (data_next_w),
                .occ_next  (occ_next_w),
                .hit_in    (hit_in_w),
                .data      (data_vec[gi]),
                .occ       (occ_vec[gi]),
                .hit_out   (hit_vec[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mask_reg <= 32'hFFFF_FFFF;
        end else if (cfg_valid && cfg_ready) begin
            key_mask_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            key_reg <= to_word(s_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !exec_go) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_cmd == CMD_EXISTS || s_cmd == CMD_REMOVE) begin
                            state_reg <= S_SEARCH;
                        end else begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_SEARCH: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec_go) begin
                        state_reg    <= S_IDLE;
                        count_reg    <= count_next;
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_next;
                        m_data_reg   <= data_out_next;
                        m_found_reg  <= found_next;
                        m_count_reg  <= 5'(count_next);
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FQSR_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `FQSR_ASSERT_IMPL(a_occ_count, aclk, aresetn, 1'b1, $countones(occ_vec) == int'(count_reg))
    `FQSR_ASSERT_NEXT(a_exec_issue, aclk, aresetn, exec_go, m_valid && state_reg == S_IDLE)
    `FQSR_ASSERT_NEXT(a_search_exec, aclk, aresetn, state_reg == S_SEARCH, state_reg == S_EXEC)

endmodule
`default_nettype wire

[verif/tb_fifo_queue_search_remove.sv]
// Self-checking testbench for the bounded queue with masked search and ordered remove.
`timescale 1ns / 1ps
module tb_fifo_queue_search_remove;
    import fqsr_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int MAX_IDLE    = 13;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 7;
    localparam int RANDOM_MASK_PHASE = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;
    localparam logic [31:0] MASK_PLAN [NUM_PHASES] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'hFFFF_0000,
        32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFE
    };

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] value;
    } cmd_beat_t;

    typedef struct {
        status_t     status;
        logic [31:0] data;
        logic        found;
        logic [4:0]  count;
    } queue_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    wire         s_ready;
    logic [2:0]  s_cmd     = CMD_ENQ;
    logic [31:0] s_value   = '0;
    wire         m_valid;
    logic        m_ready   = 1'b0;
    wire  [1:0]  m_status;
    wire  [31:0] m_data;
    wire         m_found;
    wire  [4:0]  m_count;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [31:0] cfg_data  = '0;

    cmd_beat_t     pending_cmds[$];
    queue_result_t awaited_results[$];
    logic [31:0]   model_words[$];
    logic [31:0]   model_mask = 32'hFFFF_FFFF;
    logic [31:0]   recent_words[$];
    logic [31:0]   word_pool [8];
    bit            src_idle_on  = 1'b1;
    bit            sink_idle_on = 1'b1;
    bit            cmd_took = 1'b0;
    bit            res_took = 1'b0;
    int            cmd_gap   = 0;
    int            res_stall = 0;
    int            err_count = 0;
    int            beat_no   = 0;
    int            cycle_no  = 0;

    fifo_queue_search_remove uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_found   (m_found),
        .m_count   (m_count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int draw_idle(input bit on);
        return on ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endfunction

    // Apply one command to the queue model and return the result it yields.
    function automatic queue_result_t next_queue_result(input logic [2:0] cmd,
                                                        input logic [31:0] key);
        queue_result_t r;
        int hit;
        r.status = ST_OK;
        r.data   = '0;
        r.found  = 1'b0;
        hit = -1;
        for (int i = 0; i < model_words.size() && hit < 0; i++) begin
            if (((model_words[i] ^ key) & model_mask) == '0)
                hit = i;
        end
        case (cmd)
            CMD_ENQ: begin
                if (model_words.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    model_words.push_back(key);
            end
            CMD_DEQ: begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = model_words.pop_front();
            end
            CMD_PEEK: begin
                if (model_words.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = model_words[0];
            end
            CMD_EXISTS: begin
                if (hit >= 0)
                    r.found = 1'b1;
                else
                    r.status = ST_NOTFOUND;
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    model_words.delete(hit);
                    r.found = 1'b1;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            CMD_CLEAR: begin
                model_words.delete();
            end
            default: ;
        endcase
        r.count = 5'(model_words.size());
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return word_pool[$urandom_range(0, 7)];
        if (pick < 5)
            return word_pool[$urandom_range(0, 7)] ^ (32'h1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    task automatic add_random_item(input bit filling);
        int roll;
        logic [2:0] cmd;
        logic [31:0] word;
        if (filling)
            roll = $urandom_range(0, 99);
        else
            roll = $urandom_range(30, 129);
        if (roll < 55)
            cmd = CMD_ENQ;
        else if (roll < 70)
            cmd = CMD_DEQ;
        else if (roll < 80)
            cmd = CMD_PEEK;
        else if (roll < 92)
            cmd = CMD_EXISTS;
        else if (roll < 115)
            cmd = CMD_REMOVE;
        else if (roll < 121)
            cmd = CMD_CLEAR;
        else if (roll < 125)
            cmd = CMD_SPARE6;
        else
            cmd = CMD_SPARE7;
        word = $urandom;
        if (cmd == CMD_ENQ) begin
            word = random_word();
            recent_words.push_back(word);
            if (recent_words.size() > DEPTH)
                void'(recent_words.pop_front());
        end else if (cmd == CMD_EXISTS || cmd == CMD_REMOVE) begin
            roll = $urandom_range(0, 9);
            if (recent_words.size() > 0 && roll < 6) begin
                word = recent_words[$urandom_range(0, recent_words.size() - 1)];
                // flip only bits outside the match mask
                if (roll < 2)
                    word ^= $urandom & ~model_mask;
            end else begin
                word = random_word();
            end
        end
        pending_cmds.push_back('{cmd, word});
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("%0t ns beat %0d: %s got %0h want %0h", $realtime, beat_no, what, got,
                     want);
        err_count++;
    endtask

    task automatic write_key_mask(input logic [31:0] mask);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        model_mask = mask;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    always @(negedge aclk) begin : cmd_driver
        cmd_beat_t item;
        logic next_valid;
        int next_gap;
        next_valid = s_valid && !cmd_took;
        next_gap = cmd_took ? draw_idle(src_idle_on) : cmd_gap;
        if (!next_valid && aresetn) begin
            if (next_gap > 0) begin
                next_gap--;
            end else if (pending_cmds.size() > 0) begin
                item = pending_cmds.pop_front();
                s_cmd   <= item.cmd;
                s_value <= item.value;
                next_valid = 1'b1;
            end
        end
        s_valid <= next_valid;
        cmd_gap <= next_gap;
    end

    always @(negedge aclk) begin : res_driver
        int next_stall;
        next_stall = res_took ? draw_idle(sink_idle_on) : res_stall;
        m_ready <= aresetn && next_stall == 0;
        if (next_stall > 0)
            next_stall--;
        res_stall <= next_stall;
    end

    always @(posedge aclk) begin : result_monitor
        queue_result_t want;
        cmd_took <= aresetn && s_valid && s_ready;
        res_took <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            beat_no++;
            if (awaited_results.size() == 0) begin
                flag_mismatch("result beat with none awaited", {30'd0, m_status}, '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_status !== want.status)
                    flag_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_data !== want.data)
                    flag_mismatch("data", m_data, want.data);
                if (m_found !== want.found)
                    flag_mismatch("found", 32'(m_found), 32'(want.found));
                if (m_count !== want.count)
                    flag_mismatch("count", 32'(m_count), 32'(want.count));
            end
        end
        if (aresetn && s_valid && s_ready)
            awaited_results.push_back(next_queue_result(s_cmd, s_value));
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] mask;
        logic [31:0] word;
        bit filling;
        int burst;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        pending_cmds.push_back('{CMD_DEQ, 32'h0000_0000});
        pending_cmds.push_back('{CMD_PEEK, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_EXISTS, 32'h0000_0000});
        pending_cmds.push_back('{CMD_REMOVE, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_SPARE6, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_ENQ, 32'h0000_0000});
        pending_cmds.push_back('{CMD_ENQ, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_ENQ, 32'hA5A5_5A5A});
        pending_cmds.push_back('{CMD_ENQ, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_EXISTS, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_REMOVE, 32'hFFFF_FFFF});
        pending_cmds.push_back('{CMD_PEEK, 32'h0000_0000});
        pending_cmds.push_back('{CMD_REMOVE, 32'h1234_5678});
        pending_cmds.push_back('{CMD_SPARE7, 32'h8000_0001});
        pending_cmds.push_back('{CMD_DEQ, 32'h0000_0000});
        pending_cmds.push_back('{CMD_DEQ, 32'h0000_0000});
        pending_cmds.push_back('{CMD_CLEAR, 32'h0000_0000});
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            mask = (p == RANDOM_MASK_PHASE) ? $urandom : MASK_PLAN[p];
            write_key_mask(mask);
            src_idle_on  = !(p == 1 || p == 3);
            sink_idle_on = !(p == 2 || p == 3);
            foreach (word_pool[i])
                word_pool[i] = $urandom;
            word_pool[0] = '0;
            word_pool[1] = '1;
            recent_words.delete();
            // fill past capacity on the first pass; later passes enqueue 4 to DEPTH+1 words
            burst = (p == 0) ? DEPTH + 1 : $urandom_range(4, DEPTH + 1);
            repeat (burst) begin
                word = random_word();
                recent_words.push_back(word);
                if (recent_words.size() > DEPTH)
                    void'(recent_words.pop_front());
                pending_cmds.push_back('{CMD_ENQ, word});
            end
            filling = 1'b0;
            for (int n = burst; n < PHASE_ITEMS; n++) begin
                if (n % 30 == 0)
                    filling = $urandom_range(0, 1);
                add_random_item(filling);
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (awaited_results.size() != 0)
            flag_mismatch("results never delivered", 32'(awaited_results.size()), '0);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
